// ===== hdl/hsps_pkg.sv =====
// Shared types and constants for the hull support point search core.
// Holds the item structs, the command codes and the state type; no dependencies.
`default_nettype none

package hsps_pkg;

   localparam int FIELD_W          = 16;
   localparam int DEF_MAX_VERTICES = 256;
   localparam int DEF_COORD_BITS   = 16;

   localparam logic [1:0] CMD_CLEAR  = 2'd0;
   localparam logic [1:0] CMD_APPEND = 2'd1;
   localparam logic [1:0] CMD_QUERY  = 2'd2;

   typedef struct packed {
      logic [1:0]                command;
      logic signed [FIELD_W-1:0] vertex_x;
      logic signed [FIELD_W-1:0] vertex_y;
      logic signed [FIELD_W-1:0] vertex_z;
      logic signed [FIELD_W-1:0] dir_x;
      logic signed [FIELD_W-1:0] dir_y;
      logic signed [FIELD_W-1:0] dir_z;
   } req_type;

   typedef struct packed {
      logic signed [FIELD_W-1:0] support_x;
      logic signed [FIELD_W-1:0] support_y;
      logic signed [FIELD_W-1:0] support_z;
      logic                      empty_error;
      logic                      overflow_seen;
   } rsp_type;

   typedef enum logic [1:0] {
      STATE_IDLE,
      STATE_SCAN,
      STATE_FINISH
   } state_type;

endpackage

`default_nettype wire

// ===== hdl/hull_support_point_search_core.sv =====
// Hull support point search core: vertex store, scan pipeline and result register.
// Depends on hsps_pkg for the item structs, command codes and state type.
`default_nettype none

// Keeps up to MAX_VERTICES hull vertices in a single-port-write, single-port-read
// synchronous RAM and answers support queries. Clear and append are accepted back
// to back. A query streams the stored vertices out of the RAM one per cycle
// through a read / multiply / sum / compare pipeline, and it holds the input
// stalled until the scan is done (an empty store skips the scan) and the result
// register is free to take the result. Ties keep the earliest vertex. The result
// register lets clears and appends be taken while a finished result still waits.
module hull_support_point_search_core #(
   parameter int MAX_VERTICES = hsps_pkg::DEF_MAX_VERTICES,
   parameter int COORD_BITS   = hsps_pkg::DEF_COORD_BITS
) (
   input  wire               clock,
   input  wire               reset,
   input  wire               req_valid,
   output logic              req_stall,
   input  wire hsps_pkg::req_type req_data,
   output logic              rsp_valid,
   input  wire               rsp_stall,
   output hsps_pkg::rsp_type rsp_data
);
   import hsps_pkg::*;

   localparam int ADDR_W  = (MAX_VERTICES > 1) ? $clog2(MAX_VERTICES) : 1;
   localparam int CNT_W   = $clog2(MAX_VERTICES + 1);
   localparam int ENTRY_W = 3 * COORD_BITS;
   localparam int PROD_W  = 2 * COORD_BITS;
   localparam int DOT_W   = PROD_W + 2;

   // ---------------------------------------------------------------- coordinates
   logic signed [COORD_BITS-1:0] vx_c, vy_c, vz_c, dx_c, dy_c, dz_c;

   if (COORD_BITS <= FIELD_W) begin : g_narrow_in
      assign vx_c = req_data.vertex_x[COORD_BITS-1:0];
      assign vy_c = req_data.vertex_y[COORD_BITS-1:0];
      assign vz_c = req_data.vertex_z[COORD_BITS-1:0];
      assign dx_c = req_data.dir_x[COORD_BITS-1:0];
      assign dy_c = req_data.dir_y[COORD_BITS-1:0];
      assign dz_c = req_data.dir_z[COORD_BITS-1:0];
   end else begin : g_wide_in
      // wider coordinates take the field as an unsigned value
      assign vx_c = {{(COORD_BITS-FIELD_W){1'b0}}, req_data.vertex_x};
      assign vy_c = {{(COORD_BITS-FIELD_W){1'b0}}, req_data.vertex_y};
      assign vz_c = {{(COORD_BITS-FIELD_W){1'b0}}, req_data.vertex_z};
      assign dx_c = {{(COORD_BITS-FIELD_W){1'b0}}, req_data.dir_x};
      assign dy_c = {{(COORD_BITS-FIELD_W){1'b0}}, req_data.dir_y};
      assign dz_c = {{(COORD_BITS-FIELD_W){1'b0}}, req_data.dir_z};
   end

   // ---------------------------------------------------------------- control state
   state_type              state_ff, state_in;
   logic [CNT_W-1:0]       cnt_ff, cnt_in;
   logic                   ovf_ff, ovf_in;
   logic [CNT_W-1:0]       issue_cnt_ff, issue_cnt_in;
   logic                   empty_ff, empty_in;
   logic signed [COORD_BITS-1:0] dir_x_ff, dir_y_ff, dir_z_ff;

   logic req_accept;
   logic is_clear, is_append, is_query;
   logic issue_en;
   logic scan_done;
   logic rsp_load;

   assign req_accept = req_valid && !req_stall;
   assign is_clear   = req_accept && (req_data.command == CMD_CLEAR);
   assign is_append  = req_accept && (req_data.command == CMD_APPEND);
   assign is_query   = req_accept && (req_data.command == CMD_QUERY);

   // ---------------------------------------------------------------- vertex RAM
   logic [ENTRY_W-1:0] mem [MAX_VERTICES];
   logic [ENTRY_W-1:0] rd_data_ff;
   logic               wr_en;

   assign wr_en = is_append && (cnt_ff < CNT_W'(MAX_VERTICES));

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[cnt_ff[ADDR_W-1:0]] <= {vx_c, vy_c, vz_c};
      end
      if (issue_en) begin
         rd_data_ff <= mem[issue_cnt_ff[ADDR_W-1:0]];
      end
   end

   // ---------------------------------------------------------------- scan pipeline
   logic v1_ff, v2_ff, v3_ff;
   logic signed [COORD_BITS-1:0] ex, ey, ez;
   logic signed [PROD_W-1:0]     px_ff, py_ff, pz_ff;
   logic [ENTRY_W-1:0]           e2_ff, e3_ff;
   logic signed [DOT_W-1:0]      sum_ff;
   logic signed [DOT_W-1:0]      best_ff;
   logic [ENTRY_W-1:0]           best_e_ff;
   logic                         best_valid_ff;
   logic                         take;

   assign ex = rd_data_ff[3*COORD_BITS-1:2*COORD_BITS];
   assign ey = rd_data_ff[2*COORD_BITS-1:COORD_BITS];
   assign ez = rd_data_ff[COORD_BITS-1:0];

   // strict compare: the earliest vertex keeps a tie
   assign take = v3_ff && (!best_valid_ff || (sum_ff > best_ff));

   always_ff @(posedge clock) begin
      px_ff  <= ex * dir_x_ff;
      py_ff  <= ey * dir_y_ff;
      pz_ff  <= ez * dir_z_ff;
      e2_ff  <= rd_data_ff;
      sum_ff <= DOT_W'(px_ff) + DOT_W'(py_ff) + DOT_W'(pz_ff);
      e3_ff  <= e2_ff;
      if (take) begin
         best_ff   <= sum_ff;
         best_e_ff <= e3_ff;
      end
      if (is_query) begin
         dir_x_ff <= dx_c;
         dir_y_ff <= dy_c;
         dir_z_ff <= dz_c;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         v1_ff         <= 1'b0;
         v2_ff         <= 1'b0;
         v3_ff         <= 1'b0;
         best_valid_ff <= 1'b0;
      end else begin
         v1_ff <= issue_en;
         v2_ff <= v1_ff;
         v3_ff <= v2_ff;
         if (is_query) begin
            best_valid_ff <= 1'b0;
         end else if (take) begin
            best_valid_ff <= 1'b1;
         end
      end
   end

   assign scan_done = (issue_cnt_ff == cnt_ff) && !v1_ff && !v2_ff && !v3_ff;

   // ---------------------------------------------------------------- sequencer
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         STATE_IDLE: begin
            if (is_query) begin
               state_in = (cnt_ff == '0) ? STATE_FINISH : STATE_SCAN;
            end
         end
         STATE_SCAN: begin
            if (scan_done) begin
               state_in = STATE_FINISH;
            end
         end
         STATE_FINISH: begin
            if (rsp_load) begin
               state_in = STATE_IDLE;
            end
         end
         default: state_in = STATE_IDLE;
      endcase
   end

   always_comb begin
      req_stall = 1'b1;
      issue_en  = 1'b0;
      rsp_load  = 1'b0;
      unique case (state_ff)
         STATE_IDLE:   req_stall = 1'b0;
         STATE_SCAN:   issue_en  = (issue_cnt_ff < cnt_ff);
         STATE_FINISH: rsp_load  = !rsp_valid ||! rsp_stall;
         default:      req_stall = 1'b1;
      endcase
   end

   always_comb begin
      cnt_in       = cnt_ff;
      ovf_in       = ovf_ff;
      issue_cnt_in = issue_cnt_ff;
      empty_in     = empty_ff;
      priority if (is_clear) begin
         cnt_in = '0;
         ovf_in = 1'b0;
      end else if (is_append) begin
         if (wr_en) begin
            cnt_in = cnt_ff + 1'b1;
         end else begin
            ovf_in = 1'b1;
         end
      end else if (is_query) begin
         issue_cnt_in = '0;
         empty_in     = (cnt_ff == '0);
      end else if (issue_en) begin
         issue_cnt_in = issue_cnt_ff + 1'b1;
      end else begin
         // hold
         issue_cnt_in = issue_cnt_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= STATE_IDLE;
         cnt_ff       <= '0;
         ovf_ff       <= 1'b0;
         issue_cnt_ff <= '0;
         empty_ff     <= 1'b0;
      end else begin
         state_ff     <= state_in;
         cnt_ff       <= cnt_in;
         ovf_ff       <= ovf_in;
         issue_cnt_ff <= issue_cnt_in;
         empty_ff     <= empty_in;
      end
   end

   // ---------------------------------------------------------------- result register
   logic signed [COORD_BITS-1:0] bx, by, bz;
   logic signed [FIELD_W-1:0]    ox, oy, oz;
   rsp_type                      rsp_ff, rsp_in;
   logic                         rsp_valid_ff, rsp_valid_in;

   assign bx = best_e_ff[3*COORD_BITS-1:2*COORD_BITS];
   assign by = best_e_ff[2*COORD_BITS-1:COORD_BITS];
   assign bz = best_e_ff[COORD_BITS-1:0];

   if (COORD_BITS >= FIELD_W) begin : g_wide_out
      assign ox = bx[FIELD_W-1:0];
      assign oy = by[FIELD_W-1:0];
      assign oz = bz[FIELD_W-1:0];
   end else begin : g_narrow_out
      assign ox = {{(FIELD_W-COORD_BITS){bx[COORD_BITS-1]}}, bx};
      assign oy = {{(FIELD_W-COORD_BITS){by[COORD_BITS-1]}}, by};
      assign oz = {{(FIELD_W-COORD_BITS){bz[COORD_BITS-1]}}, bz};
   end

   always_comb begin
      rsp_in               = rsp_ff;
      rsp_valid_in         = rsp_valid_ff;
      if (rsp_load) begin
         rsp_valid_in          = 1'b1;
         rsp_in.support_x      = empty_ff ? '0 : ox;
         rsp_in.support_y      = empty_ff ? '0 : oy;
         rsp_in.support_z      = empty_ff ? '0 : oz;
         rsp_in.empty_error    = empty_ff;
         rsp_in.overflow_seen  = ovf_ff;
      end else if (!rsp_stall) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      rsp_ff <= rsp_in;
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;

   // ---------------------------------------------------------------- assertions
   a_cnt_bound: assert property (@(posedge clock) disable iff (reset)
      cnt_ff <= CNT_W'(MAX_VERTICES))
      else $error("vertex count beyond store depth");

   a_cnt_stable_scan: assert property (@(posedge clock) disable iff (reset)
      (state_ff == STATE_SCAN) |=> $stable(cnt_ff))
      else $error("vertex count changed during a scan");

   a_issue_bound: assert property (@(posedge clock) disable iff (reset)
      (state_ff == STATE_SCAN) |-> (issue_cnt_ff <= cnt_ff))
      else $error("scan read beyond stored vertices");

   a_best_ready: assert property (@(posedge clock) disable iff (reset)
      (state_ff == STATE_FINISH && !empty_ff) |-> best_valid_ff)
      else $error("finished a non-empty scan with no candidate");

   a_rsp_from_finish: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && !$past(rsp_valid_ff)) |-> ($past(state_ff) == STATE_FINISH))
      else $error("result loaded outside the finish state");

endmodule

`default_nettype wire

// ===== test/hull_support_point_search_core_test.sv =====
// Testbench for hull_support_point_search_core: clear, append and support queries
// are checked against an in-bench hull store model under varied idling.
// Depends on hsps_pkg and the core RTL only.
module hull_support_point_search_core_test;
   timeunit 1ns;
   timeprecision 1ps;

   import hsps_pkg::*;

   localparam int         STORE_DEPTH = DEF_MAX_VERTICES;
   localparam logic [1:0] CMD_UNUSED  = 2'd3;
   localparam int         ITEM_BUDGET = 1550;

   logic    clock     = 1'b0;
   logic    reset     = 1'b1;
   logic    req_valid = 1'b0;
   logic    req_stall;
   req_type req_data  = '0;
   logic    rsp_valid;
   logic    rsp_stall = 1'b0;
   rsp_type rsp_data;

   int sender_idle_pct    = 0;
   int receiver_stall_pct = 0;

   // Hull store as the block should see it.
   logic signed [FIELD_W-1:0] hull_x [STORE_DEPTH];
   logic signed [FIELD_W-1:0] hull_y [STORE_DEPTH];
   logic signed [FIELD_W-1:0] hull_z [STORE_DEPTH];
   int      hull_count    = 0;
   logic    overflow_flag = 1'b0;
   rsp_type pending_supports[$];

   int items_sent       = 0;
   int queries_sent     = 0;
   int empty_queries    = 0;
   int dropped_appends  = 0;
   int supports_checked = 0;
   int mismatch_count   = 0;

   hull_support_point_search_core dut (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp_data  (rsp_data)
   );

   always #6 clock = ~clock;

   initial begin
      #40ms;
      $display("hull_support_point_search_core test failed");
      $finish;
   end

   always @(posedge clock) begin
      rsp_stall <= ($urandom_range(99) < receiver_stall_pct);
   end

   function automatic longint hull_dot(req_type item, int idx);
      return longint'($signed(item.dir_x)) * longint'(hull_x[idx])
           + longint'($signed(item.dir_y)) * longint'(hull_y[idx])
           + longint'($signed(item.dir_z)) * longint'(hull_z[idx]);
   endfunction

   function automatic void update_hull(req_type item);
      rsp_type want;
      longint  best_dot;
      longint  dot;
      int      best;
      case (item.command)
         CMD_CLEAR: begin
            hull_count    = 0;
            overflow_flag = 1'b0;
         end
         CMD_APPEND: begin
            if (hull_count < STORE_DEPTH) begin
               hull_x[hull_count] = item.vertex_x;
               hull_y[hull_count] = item.vertex_y;
               hull_z[hull_count] = item.vertex_z;
               hull_count++;
            end else begin
               overflow_flag = 1'b1;
               dropped_appends++;
            end
         end
         CMD_QUERY: begin
            want = '0;
            queries_sent++;
            if (hull_count == 0) begin
               want.empty_error = 1'b1;
               empty_queries++;
            end else begin
               best     = 0;
               best_dot = hull_dot(item, 0);
               // strict compare: ties keep the earliest vertex
               for (int i = 1; i < hull_count; i++) begin
                  dot = hull_dot(item, i);
                  if (dot > best_dot) begin
                     best_dot = dot;
                     best     = i;
                  end
               end
               want.support_x = hull_x[best];
               want.support_y = hull_y[best];
               want.support_z = hull_z[best];
            end
            want.overflow_seen = overflow_flag;
            pending_supports.push_back(want);
         end
         default: ;
      endcase
   endfunction

   function automatic void check_field(string name, int want, int got);
      if (want != got) begin
         $error("%s: expected %0d, got %0d", name, want, got);
         mismatch_count++;
      end
   endfunction

   always @(posedge clock) begin
      rsp_type want;
      if (!reset && rsp_valid === 1'b1 && !rsp_stall) begin
         if (pending_supports.size() == 0) begin
            $error("support result with none expected: %h", rsp_data);
            mismatch_count++;
         end else begin
            want = pending_supports.pop_front();
            supports_checked++;
            check_field("support_x", want.support_x, rsp_data.support_x);
            check_field("support_y", want.support_y, rsp_data.support_y);
            check_field("support_z", want.support_z, rsp_data.support_z);
            check_field("empty_error", want.empty_error, rsp_data.empty_error);
            check_field("overflow_seen", want.overflow_seen, rsp_data.overflow_seen);
         end
      end
   end

   // Hold the item until the block takes it; valid stays up for a following item.
   task automatic send_item(req_type item);
      while ($urandom_range(99) < sender_idle_pct) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid <= 1'b1;
      req_data  <= item;
      do @(posedge clock); while (req_stall);
      update_hull(item);
      if (item.command != CMD_UNUSED) items_sent++;
   endtask

   task automatic drain_results();
      req_valid <= 1'b0;
      @(posedge clock);
      while (pending_supports.size() != 0) @(posedge clock);
   endtask

   function automatic logic [FIELD_W-1:0] pick_coord();
      logic [FIELD_W-1:0] corners [5] = '{16'h8000, 16'h7FFF, 16'h0000, 16'hFFFF, 16'h0001};
      case ($urandom_range(3))
         0, 1:    return FIELD_W'($urandom);
         2:       return FIELD_W'($urandom_range(6)) - FIELD_W'(3);
         default: return corners[$urandom_range(4)];
      endcase
   endfunction

   // Place a, b, c where the command reads them; fill the unused fields at random.
   function automatic req_type hull_item(logic [1:0] cmd, logic [FIELD_W-1:0] a,
                                         logic [FIELD_W-1:0] b, logic [FIELD_W-1:0] c);
      req_type item;
      item.command  = cmd;
      item.vertex_x = (cmd == CMD_APPEND) ? a : FIELD_W'($urandom);
      item.vertex_y = (cmd == CMD_APPEND) ? b : FIELD_W'($urandom);
      item.vertex_z = (cmd == CMD_APPEND) ? c : FIELD_W'($urandom);
      item.dir_x    = (cmd == CMD_QUERY)  ? a : FIELD_W'($urandom);
      item.dir_y    = (cmd == CMD_QUERY)  ? b : FIELD_W'($urandom);
      item.dir_z    = (cmd == CMD_QUERY)  ? c : FIELD_W'($urandom);
      return item;
   endfunction

   function automatic req_type random_item(logic [1:0] cmd);
      return hull_item(cmd, pick_coord(), pick_coord(), pick_coord());
   endfunction

   task automatic test_empty_store();
      send_item(hull_item(CMD_QUERY, 16'h7FFF, 16'h8000, 16'h0001));
      send_item(random_item(CMD_UNUSED));
      send_item(hull_item(CMD_QUERY, 16'h0000, 16'h0000, 16'h0000));
      drain_results();
   endtask

   task automatic test_extreme_fields();
      send_item(random_item(CMD_CLEAR));
      send_item(hull_item(CMD_APPEND, 16'h8000, 16'h8000, 16'h8000));
      send_item(hull_item(CMD_APPEND, 16'h7FFF, 16'h7FFF, 16'h7FFF));
      send_item(hull_item(CMD_APPEND, 16'h0000, 16'h0000, 16'h0000));
      send_item(hull_item(CMD_APPEND, 16'hFFFF, 16'h0001, 16'hFFFF));
      send_item(hull_item(CMD_APPEND, 16'h7FFF, 16'h8000, 16'h0000));
      send_item(hull_item(CMD_QUERY, 16'h7FFF, 16'h7FFF, 16'h7FFF));
      send_item(hull_item(CMD_QUERY, 16'h8000, 16'h8000, 16'h8000));
      send_item(hull_item(CMD_QUERY, 16'h0000, 16'h0000, 16'h0000));
      send_item(hull_item(CMD_QUERY, 16'h7FFF, 16'h8000, 16'h0000));
      send_item(random_item(CMD_UNUSED));
      send_item(hull_item(CMD_QUERY, 16'hFFFF, 16'h0000, 16'h0000));
      // equal dot products: the first of the tied vertices must win
      send_item(random_item(CMD_CLEAR));
      send_item(hull_item(CMD_APPEND, 16'h0100, 16'h0000, 16'h0000));
      send_item(hull_item(CMD_APPEND, 16'h0000, 16'h0100, 16'h0000));
      send_item(hull_item(CMD_APPEND, 16'h0100, 16'h0000, 16'h0000));
      send_item(hull_item(CMD_QUERY, 16'h0100, 16'h0100, 16'h0000));
      send_item(hull_item(CMD_QUERY, 16'h0000, 16'h0000, 16'h8000));
      send_item(random_item(CMD_CLEAR));
      send_item(random_item(CMD_QUERY));
      drain_results();
   endtask

   task automatic test_store_overflow();
      send_item(random_item(CMD_CLEAR));
      repeat (STORE_DEPTH + 3) send_item(random_item(CMD_APPEND));
      repeat (3) send_item(random_item(CMD_QUERY));
      send_item(random_item(CMD_CLEAR));
      send_item(random_item(CMD_QUERY));
      drain_results();
   endtask

   task automatic random_hull_sequence();
      int roll;
      int vertex_total;
      if ($urandom_range(99) < 80) send_item(random_item(CMD_CLEAR));
      roll = $urandom_range(99);
      if (roll < 2)      vertex_total = $urandom_range(200, STORE_DEPTH + 6);
      else if (roll < 6) vertex_total = $urandom_range(20, 80);
      else               vertex_total = $urandom_range(12);
      for (int i = 0; i < vertex_total; i++) begin
         // occasional noise: any command, unused code included
         if ($urandom_range(99) < 4) send_item(random_item(2'($urandom_range(3))));
         else                        send_item(random_item(CMD_APPEND));
      end
      repeat ($urandom_range(1, 5)) send_item(random_item(CMD_QUERY));
   endtask

   task automatic test_random_hulls();
      int idle_pcts  [4] = '{0, 71, 0, 34};
      int stall_pcts [4] = '{0, 0, 71, 34};
      int phase_end;
      for (int p = 0; p < 4; p++) begin
         sender_idle_pct    = idle_pcts[p];
         receiver_stall_pct = stall_pcts[p];
         phase_end = items_sent + (ITEM_BUDGET - items_sent) / (4 - p);
         while (items_sent < phase_end) random_hull_sequence();
         drain_results();
      end
   endtask

   initial begin
      repeat (12) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      test_empty_store();
      test_extreme_fields();
      sender_idle_pct    = 34;
      receiver_stall_pct = 34;
      test_store_overflow();
      test_random_hulls();
      req_valid <= 1'b0;
      while (pending_supports.size() != 0) @(posedge clock);
      repeat (STORE_DEPTH + 16) @(posedge clock);
      $display("Sent %0d items: %0d queries (%0d on an empty store), %0d appends dropped.",
               items_sent, queries_sent, empty_queries, dropped_appends);
      $display("Checked %0d support results across four idle and stall mixes.",
               supports_checked);
      if (mismatch_count == 0 && pending_supports.size() == 0) begin
         $display("hull_support_point_search_core test passed");
      end else begin
         $display("hull_support_point_search_core test failed");
      end
      $finish;
   end

endmodule
